// File: design/pdt_pkg.sv
// Shared types and constants for the posture deduplication table.
// Depends on nothing; pdt_lane, pdt_merge and the top level import it.
package pdt_pkg;

  localparam int LIMIT_W    = 33;
  localparam int ANGLE_IN_W = 16;
  localparam int IN_JOINTS  = 8;
  localparam int COUNT_W    = 4;
  localparam int INDEX_W    = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 33'd980;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } pdt_state_t;

endpackage

// File: design/pdt_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module pdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/pdt_lane.sv
// One joint lane: wrapped angle difference, magnitude and its square.
// Two register stages; depends on pdt_pkg for nothing beyond the house import.
module pdt_lane
  import pdt_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    active,
  input  logic [ANGLE_BITS-1:0]   angle_in,
  input  logic [ANGLE_BITS-1:0]   angle_stored,
  output logic [2*ANGLE_BITS-1:0] sq
);

  logic [ANGLE_BITS-1:0]   diff;
  logic [ANGLE_BITS-1:0]   mag;
  logic [ANGLE_BITS-1:0]   mag_r;
  logic [2*ANGLE_BITS-1:0] sq_r;

  always_comb begin
    diff = angle_in - angle_stored;
    mag  = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
    if (!active) begin
      mag = '0;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag;
    sq_r  <= (2*ANGLE_BITS)'(mag_r) * (2*ANGLE_BITS)'(mag_r);
  end

  assign sq = sq_r;

endmodule

// File: design/pdt_merge.sv
// Merging stage: sums the lane squares and compares against the limit.
// Depends on pdt_pkg for the limit width.
module pdt_merge
  import pdt_pkg::*;
#(
  parameter int MAX_JOINTS = 8,
  parameter int ANGLE_BITS = 16
) (
  input  logic                    clk,
  input  logic [2*ANGLE_BITS-1:0] sq [MAX_JOINTS],
  input  logic [LIMIT_W-1:0]      limit,
  output logic                    below
);

  localparam int SW = 2 * ANGLE_BITS + 4;
  localparam int CW = (SW > LIMIT_W) ? SW : LIMIT_W;

  logic [SW-1:0] sum;
  logic [SW-1:0] sum_r;

  always_comb begin
    sum = '0;
    for (int j = 0; j < MAX_JOINTS; j++) begin
      sum = sum + {4'b0000, sq[j]};
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum;
  end

  assign below = CW'(sum_r) < CW'(limit);

endmodule

// File: design/posture_dedup_table.sv
// Posture deduplication table: top level with control, memory and lanes.
// Depends on pdt_pkg, pdt_ram, pdt_lane and pdt_merge.
//
// Each input beat is one posture. The block reads its stored postures one
// entry per cycle through the single read port of the posture memory, and
// MAX_JOINTS lanes compare all joints of that entry at once; a merge stage
// sums the squared distances and tests them against match_limit_sq. The
// scan stops at the first match. The one-entry-per-cycle scan and the
// four-stage compare pipeline set the time from one accepted beat to the
// next, which grows with the fill level and shrinks when an early entry
// matches; a held output also delays it. One item at a time is in work.
// The memory needs no clearing after reset, since only entries below the
// fill level are read. The configuration register is writable in any cycle
// and should only be changed while the block is idle.
module posture_dedup_table
  import pdt_pkg::*;
#(
  parameter int MAX_JOINTS  = 8,
  parameter int TABLE_DEPTH = 64,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_match_limit_sq,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_W-1:0]    in_joint_count,
  input  logic [ANGLE_IN_W-1:0] in_angle_0,
  input  logic [ANGLE_IN_W-1:0] in_angle_1,
  input  logic [ANGLE_IN_W-1:0] in_angle_2,
  input  logic [ANGLE_IN_W-1:0] in_angle_3,
  input  logic [ANGLE_IN_W-1:0] in_angle_4,
  input  logic [ANGLE_IN_W-1:0] in_angle_5,
  input  logic [ANGLE_IN_W-1:0] in_angle_6,
  input  logic [ANGLE_IN_W-1:0] in_angle_7,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_W-1:0]    out_entry_index,
  output logic                  out_is_new,
  output logic                  out_table_full
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = MAX_JOINTS * ANGLE_BITS + COUNT_W;

  pdt_state_t state_r, state_nxt;

  logic [LIMIT_W-1:0]    limit_r;
  logic [FW-1:0]         fill_r;
  logic [FW-1:0]         scan_r;
  logic                  found_r;
  logic [AW-1:0]         found_idx_r;
  logic [COUNT_W-1:0]    count_r;
  logic [ANGLE_BITS-1:0] vec_r [MAX_JOINTS];

  logic                  out_valid_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic                  out_new_r;
  logic                  out_full_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic ok2_r, ok3_r, ok4_r;
  logic [AW-1:0] idx1_r, idx2_r, idx3_r, idx4_r;

  logic [ANGLE_IN_W-1:0] in_ang [IN_JOINTS];
  logic [ANGLE_BITS-1:0] in_vec [MAX_JOINTS];
  logic [COUNT_W-1:0]    in_count_sat;

  logic                  in_take;
  logic                  issue;
  logic                  hit;
  logic                  pipe_empty;
  logic                  out_free;
  logic                  finish;
  logic                  table_is_full;
  logic                  do_write;

  logic [RW-1:0]         rdata;
  logic [RW-1:0]         wdata;
  logic [COUNT_W-1:0]    rd_count;
  logic [2*ANGLE_BITS-1:0] lane_sq [MAX_JOINTS];
  logic                  below;

  logic [AW+INDEX_W-1:0] found_ix_ext;
  logic [AW+INDEX_W-1:0] fill_ix_ext;

  assign in_ang[0] = in_angle_0;
  assign in_ang[1] = in_angle_1;
  assign in_ang[2] = in_angle_2;
  assign in_ang[3] = in_angle_3;
  assign in_ang[4] = in_angle_4;
  assign in_ang[5] = in_angle_5;
  assign in_ang[6] = in_angle_6;
  assign in_ang[7] = in_angle_7;

  // Angle bits above ANGLE_BITS are dropped; joints beyond the port count read as zero.
  always_comb begin
    logic [ANGLE_BITS+ANGLE_IN_W-1:0] ext;
    for (int j = 0; j < MAX_JOINTS; j++) begin
      ext = '0;
      if (j < IN_JOINTS) begin
        ext = {{ANGLE_BITS{1'b0}}, in_ang[j]};
      end
      in_vec[j] = ext[ANGLE_BITS-1:0];
    end
  end

  assign in_count_sat = (in_joint_count > COUNT_W'(MAX_JOINTS)) ? COUNT_W'(MAX_JOINTS)
                                                                 : in_joint_count;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;

  assign rd_count      = rdata[RW-1 -: COUNT_W];
  assign hit           = v4_r && ok4_r && below;
  assign issue         = (state_r == ST_SCAN) && (scan_r < fill_r) && !found_r && !hit;
  assign pipe_empty    = !(v1_r || v2_r || v3_r || v4_r);
  assign out_free      = !out_valid_r || out_ready;
  assign finish        = (state_r == ST_DRAIN) && pipe_empty && out_free;
  assign table_is_full = (fill_r == FW'(TABLE_DEPTH));
  assign do_write      = finish && !found_r && !table_is_full;

  always_comb begin
    wdata[RW-1 -: COUNT_W] = count_r;
    for (int j = 0; j < MAX_JOINTS; j++) begin
      wdata[j*ANGLE_BITS +: ANGLE_BITS] = vec_r[j];
    end
  end

  assign found_ix_ext = {{INDEX_W{1'b0}}, found_idx_r};
  assign fill_ix_ext  = {{INDEX_W{1'b0}}, fill_r[AW-1:0]};

  pdt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (fill_r[AW-1:0]),
    .wdata (wdata),
    .re    (issue),
    .raddr (scan_r[AW-1:0]),
    .rdata (rdata)
  );

  for (genvar g = 0; g < MAX_JOINTS; g++) begin : g_lane
    pdt_lane #(
      .ANGLE_BITS (ANGLE_BITS)
    ) u_lane (
      .clk          (clk),
      .active       (count_r > COUNT_W'(g)),
      .angle_in     (vec_r[g]),
      .angle_stored (rdata[g*ANGLE_BITS +: ANGLE_BITS]),
      .sq           (lane_sq[g])
    );
  end

  pdt_merge #(
    .MAX_JOINTS (MAX_JOINTS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_merge (
    .clk   (clk),
    .sq    (lane_sq),
    .limit (limit_r),
    .below (below)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      fill_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_match_limit_sq;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (in_take) begin
        found_r <= 1'b0;
      end else if (hit && !found_r) begin
        found_r <= 1'b1;
      end
      if (do_write) begin
        fill_r <= fill_r + 1'b1;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      count_r <= in_count_sat;
      scan_r  <= '0;
      for (int j = 0; j < MAX_JOINTS; j++) begin
        vec_r[j] <= in_vec[j];
      end
    end else if (issue) begin
      scan_r <= scan_r + 1'b1;
    end
    if (hit && !found_r) begin
      found_idx_r <= idx4_r;
    end
    idx1_r <= scan_r[AW-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    ok2_r  <= (rd_count == count_r);
    ok3_r  <= ok2_r;
    ok4_r  <= ok3_r;
    if (finish) begin
      if (found_r) begin
        out_index_r <= found_ix_ext[INDEX_W-1:0];
        out_new_r   <= 1'b0;
        out_full_r  <= 1'b0;
      end else if (table_is_full) begin
        out_index_r <= '0;
        out_new_r   <= 1'b0;
        out_full_r  <= 1'b1;
      end else begin
        out_index_r <= fill_ix_ext[INDEX_W-1:0];
        out_new_r   <= 1'b1;
        out_full_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_index_r;
  assign out_is_new      = out_new_r;
  assign out_table_full  = out_full_r;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for posture_dedup_table: a scoreboard class that keeps its own
// copy of the posture table, with directed and random postures. Depends on pdt_pkg and the RTL.

typedef struct packed {
  logic [3:0]       count;
  logic [7:0][15:0] angle;
} posture_t;

typedef struct packed {
  logic [5:0] index;
  logic       is_new;
  logic       full;
} lookup_t;

class dedup_checker;
  logic [7:0][15:0] stored_angles [64];
  logic [3:0]       stored_counts [64];
  int unsigned      stored_fill;
  logic [32:0]      limit;
  lookup_t          expected_lookups [$];
  int unsigned      fail_count;

  function new();
    limit       = pdt_pkg::LIMIT_RESET;
    stored_fill = 0;
    fail_count  = 0;
  endfunction

  function automatic lookup_t predict_lookup(posture_t p);
    lookup_t     r;
    int unsigned n;
    bit          hit;
    logic [15:0] d;
    logic [15:0] m;
    logic [63:0] dist_sq;
    r   = '0;
    hit = 1'b0;
    n   = (p.count > 8) ? 8 : p.count;
    for (int unsigned e = 0; e < stored_fill && !hit; e++) begin
      if (stored_counts[e] == n) begin
        dist_sq = '0;
        for (int j = 0; j < n; j++) begin
          d = p.angle[j] - stored_angles[e][j];
          m = (d > 16'h8000) ? 16'h0 - d : d;
          dist_sq += 64'(m) * 64'(m);
        end
        if (dist_sq < 64'(limit)) begin
          hit     = 1'b1;
          r.index = 6'(e);
        end
      end
    end
    if (!hit) begin
      if (stored_fill >= 64) begin
        r.full = 1'b1;
      end else begin
        stored_angles[stored_fill] = p.angle;
        stored_counts[stored_fill] = 4'(n);
        r.index                    = 6'(stored_fill);
        r.is_new                   = 1'b1;
        stored_fill++;
      end
    end
    return r;
  endfunction

  function void note_posture(posture_t p);
    lookup_t want;
    want             = predict_lookup(p);
    expected_lookups = {expected_lookups, want};
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH: %s", what);
    fail_count++;
  endtask

  task check_lookup(lookup_t got);
    lookup_t want;
    if (expected_lookups.size() == 0) begin
      report_mismatch($sformatf("result beat with no posture pending (index %0d)", got.index));
    end else begin
      want = expected_lookups.pop_front();
      if (got.index != want.index)
        report_mismatch($sformatf("entry_index %0d, predicted %0d", got.index, want.index));
      if (got.is_new != want.is_new)
        report_mismatch($sformatf("is_new %0b, predicted %0b", got.is_new, want.is_new));
      if (got.full != want.full)
        report_mismatch($sformatf("table_full %0b, predicted %0b", got.full, want.full));
    end
  endtask
endclass

module tb_top;
  import pdt_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [LIMIT_W-1:0]    cfg_match_limit_sq = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COUNT_W-1:0]    in_joint_count = '0;
  logic [ANGLE_IN_W-1:0] in_angle_0 = '0;
  logic [ANGLE_IN_W-1:0] in_angle_1 = '0;
  logic [ANGLE_IN_W-1:0] in_angle_2 = '0;
  logic [ANGLE_IN_W-1:0] in_angle_3 = '0;
  logic [ANGLE_IN_W-1:0] in_angle_4 = '0;
  logic [ANGLE_IN_W-1:0] in_angle_5 = '0;
  logic [ANGLE_IN_W-1:0] in_angle_6 = '0;
  logic [ANGLE_IN_W-1:0] in_angle_7 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [INDEX_W-1:0]    out_entry_index;
  logic                  out_is_new;
  logic                  out_table_full;

  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  dedup_checker sb = new();

  posture_dedup_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_match_limit_sq (cfg_match_limit_sq),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_joint_count     (in_joint_count),
    .in_angle_0         (in_angle_0),
    .in_angle_1         (in_angle_1),
    .in_angle_2         (in_angle_2),
    .in_angle_3         (in_angle_3),
    .in_angle_4         (in_angle_4),
    .in_angle_5         (in_angle_5),
    .in_angle_6         (in_angle_6),
    .in_angle_7         (in_angle_7),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_index    (out_entry_index),
    .out_is_new         (out_is_new),
    .out_table_full     (out_table_full)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Both channels are sampled at the edge, before this step's driven values land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_posture('{in_joint_count, {in_angle_7, in_angle_6, in_angle_5, in_angle_4,
                                          in_angle_3, in_angle_2, in_angle_1, in_angle_0}});
      if (out_valid && out_ready)
        sb.check_lookup('{out_entry_index, out_is_new, out_table_full});
    end
  end

  function automatic posture_t uniform_posture(logic [3:0] count, logic [15:0] value);
    posture_t p;
    p.count = count;
    for (int j = 0; j < 8; j++) p.angle[j] = value;
    return p;
  endfunction

  function automatic posture_t random_posture();
    posture_t    p;
    int unsigned pick;
    int unsigned e;
    int unsigned spread;
    logic [15:0] extremes [4];
    extremes = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    pick = $urandom_range(99);
    p.count = 4'($urandom_range(15));
    p.angle = {$urandom(), $urandom(), $urandom(), $urandom()};
    if (sb.stored_fill != 0 && pick < 75) begin
      e      = $urandom_range(sb.stored_fill - 1);
      spread = ($urandom_range(3) == 0) ? 40 : 11;
      p.count = sb.stored_counts[e];
      if (p.count == 8 && $urandom_range(3) == 0) p.count = 4'($urandom_range(15, 9));
      for (int j = 0; j < 8; j++) begin
        if (j < sb.stored_counts[e])
          p.angle[j] = sb.stored_angles[e][j] + 16'($urandom_range(2 * spread) - spread);
      end
      if (pick < 5) p.angle[$urandom_range(7)] += 16'h8000;
    end else if (pick >= 90) begin
      p = uniform_posture(4'($urandom_range(15)), extremes[$urandom_range(3)]);
    end
    return p;
  endfunction

  task automatic send_posture(posture_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_joint_count <= p.count;
    in_angle_0     <= p.angle[0];
    in_angle_1     <= p.angle[1];
    in_angle_2     <= p.angle[2];
    in_angle_3     <= p.angle[3];
    in_angle_4     <= p.angle[4];
    in_angle_5     <= p.angle[5];
    in_angle_6     <= p.angle[6];
    in_angle_7     <= p.angle[7];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle_table();
    in_valid <= 1'b0;
    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    cfg_valid          <= 1'b1;
    cfg_match_limit_sq <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.limit = value;
  endtask

  initial begin
    posture_t    p;
    logic [32:0] phase_limit [4];
    int unsigned phase_idle [4];
    int unsigned phase_stall [4];
    int unsigned phase_items [4];
    phase_limit = '{33'd980, 33'($urandom_range(200000, 1)), 33'd0, {33{1'b1}}};
    phase_idle  = '{0, 74, 0, 36};
    phase_stall = '{0, 0, 74, 36};
    phase_items = '{200, 200, 150, 250};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_posture(uniform_posture(4'd0, 16'h0000));
    p = uniform_posture(4'd0, 16'h0000);
    p.angle = {$urandom(), $urandom(), $urandom(), $urandom()};
    send_posture(p);
    send_posture(uniform_posture(4'd8, 16'h0000));
    send_posture(uniform_posture(4'd8, 16'hFFFF));
    send_posture(uniform_posture(4'd15, 16'h8000));
    p = uniform_posture(4'd12, 16'h8000);
    p.angle[3] = 16'h8007;
    send_posture(p);
    // A squared distance of exactly the limit must not match; one below must.
    p = uniform_posture(4'd8, 16'h0000);
    p.angle[0] = 16'd28;
    p.angle[1] = 16'hFFF2;
    send_posture(p);
    p.angle[1] = 16'hFFF3;
    p.angle[2] = 16'd5;
    p.angle[3] = 16'd1;
    send_posture(p);
    send_posture(uniform_posture(4'd1, 16'h1234));
    p = uniform_posture(4'd1, 16'h1253);
    p.angle[7:1] = {$urandom(), $urandom(), $urandom(), 16'($urandom())};
    send_posture(p);
    send_posture(uniform_posture(4'd1, 16'h1215));
    send_posture(uniform_posture(4'd1, 16'h9234));
    send_posture(uniform_posture(4'd4, 16'h7FFF));
    send_posture(uniform_posture(4'd4, 16'hFFFF));
    send_posture(uniform_posture(4'd4, 16'h7FF0));
    settle_table();
    write_limit('0);
    send_posture(uniform_posture(4'd0, 16'h0000));
    send_posture(uniform_posture(4'd8, 16'h0000));
    settle_table();
    write_limit({LIMIT_W{1'b1}});
    send_posture(uniform_posture(4'd8, 16'h8000));
    p = uniform_posture(4'd8, 16'h0000);
    p.angle = {$urandom(), $urandom(), $urandom(), $urandom()};
    send_posture(p);
    p.count = 4'd3;
    send_posture(p);
    p.angle = {$urandom(), $urandom(), $urandom(), $urandom()};
    send_posture(p);

    for (int ph = 0; ph < 4; ph++) begin
      settle_table();
      write_limit(phase_limit[ph]);
      send_idle_pct = phase_idle[ph];
      stall_pct     = phase_stall[ph];
      for (int i = 0; i < phase_items[ph]; i++) begin
        if (ph == 1 && i == phase_items[ph] / 2) settle_table();
        send_posture(random_posture());
      end
    end

    settle_table();
    repeat (80) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pdt_pkg.sv
design/pdt_ram.sv
design/pdt_lane.sv
design/pdt_merge.sv
design/posture_dedup_table.sv
tb/sv/tb_top.sv
